// File: rtl/core/lpl_pkg.sv
// shared types, widths and register codes of the level linearizer
`default_nettype none

package lpl_pkg;

    localparam int MEAS_W     = 48;
    localparam int FS_W       = 32;
    localparam int TOP_W      = 39;
    localparam int NUM_W      = 46;
    localparam int FILL_W     = 14;
    localparam int VOL_W      = 15;
    localparam int DAC_W      = 12;
    localparam int PT_W       = 8;
    localparam int PLO_W      = 64;
    localparam int PHI_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_DATA_W = 48;
    localparam int DIV_STAGES = FILL_W;

    localparam logic [FILL_W-1:0] FILL_MAX = 14'd10000;
    localparam logic [VOL_W-1:0]  VOL_MAX  = 15'd25500;

    localparam logic [FS_W-1:0]   FULL_SCALE_RST  = 32'd0;
    localparam logic [PLO_W-1:0]  POINTS_LOW_RST  = 64'h463C_3228_1E14_0A00;
    localparam logic [PHI_W-1:0]  POINTS_HIGH_RST = 24'h645A50;
    localparam logic [GAIN_W-1:0] DAC_GAIN_RST    = 16'd12409;
    localparam logic [GAIN_W-1:0] DAC_OFFSET_RST  = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_SCALE  = 3'd0,
        REG_POINTS_LOW  = 3'd1,
        REG_POINTS_HIGH = 3'd2,
        REG_DAC_GAIN    = 3'd3,
        REG_DAC_OFFSET  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [FS_W-1:0]   full_scale;
        logic [PLO_W-1:0]  points_low;
        logic [PHI_W-1:0]  points_high;
        logic [GAIN_W-1:0] dac_gain;
        logic [GAIN_W-1:0] dac_offset;
    } t_cfg;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              inv;
    } t_tag;

endpackage

`default_nettype wire

// File: rtl/core/level_percent_linearize_dac_unit.sv
// top level of the tank level linearizer with dac code output
//
// One measured level word in, one result word out, at a sustained rate of one word
// per clock while the output is taken, through 25 register stages: clamp and scale
// take two stages, the fill division 14 stages (one quotient bit each, set by the
// 14-bit fill), the table interpolation five and the dac scaling four. Every stage
// holds its word while the next one is full, so bubbles close up under output stall
// and input stays ready whenever the output register is empty or being taken. The user
// must write registers only while no word is in flight; the block does not enforce it.
`default_nettype none

module level_percent_linearize_dac_unit
    import lpl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [MEAS_W-1:0]     i_s_axis_tdata,   // measured
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // fill_percent, volume_percent, dac_code
    output logic                       o_m_axis_tuser,   // calib_invalid
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg             w_cfg;
    logic             w_div_valid;
    logic             w_div_ready;
    t_tag             w_div_tag;
    logic             w_int_valid;
    logic             w_int_ready;
    t_tag             w_int_tag;
    logic [VOL_W-1:0] w_int_vol;
    t_tag             w_out_tag;
    logic [VOL_W-1:0] w_out_vol;
    logic [DAC_W-1:0] w_out_code;

    lpl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    lpl_fill_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_measured (i_s_axis_tdata),
        .o_valid    (w_div_valid),
        .i_ready    (w_div_ready),
        .o_tag      (w_div_tag)
    );

    lpl_interp u_int (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_tag   (w_div_tag),
        .o_valid (w_int_valid),
        .i_ready (w_int_ready),
        .o_tag   (w_int_tag),
        .o_vol   (w_int_vol)
    );

    lpl_dac u_dac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_int_valid),
        .o_ready (w_int_ready),
        .i_tag   (w_int_tag),
        .i_vol   (w_int_vol),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_tag   (w_out_tag),
        .o_vol   (w_out_vol),
        .o_code  (w_out_code)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - FILL_W - VOL_W - DAC_W)'(0),
                             w_out_code, w_out_vol, w_out_tag.fill};
    assign o_m_axis_tuser = w_out_tag.inv;

    a_inv_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (w_out_tag.fill == '0))
        else $error("fill not zero with invalid calibration");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_out_tag.fill <= FILL_MAX))
        else $error("fill out of range");

    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_out_vol <= VOL_MAX))
        else $error("volume out of range");

    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input held off while output drains");

endmodule

`default_nettype wire

// File: rtl/core/lpl_cfg_regs.sv
// calibration and table registers behind the write port
`default_nettype none

module lpl_cfg_regs
    import lpl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_scale  <= FULL_SCALE_RST;
            r_cfg.points_low  <= POINTS_LOW_RST;
            r_cfg.points_high <= POINTS_HIGH_RST;
            r_cfg.dac_gain    <= DAC_GAIN_RST;
            r_cfg.dac_offset  <= DAC_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FULL_SCALE:  r_cfg.full_scale  <= i_cfg_wdata[FS_W-1:0];
                REG_POINTS_LOW:  r_cfg.points_low  <= i_cfg_wdata[PLO_W-1:0];
                REG_POINTS_HIGH: r_cfg.points_high <= i_cfg_wdata[PHI_W-1:0];
                REG_DAC_GAIN:    r_cfg.dac_gain    <= i_cfg_wdata[GAIN_W-1:0];
                REG_DAC_OFFSET:  r_cfg.dac_offset  <= i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/lpl_fill_div.sv
// clamp, scale and restoring divider giving the fill in hundredths of a percent
`default_nettype none

module lpl_fill_div
    import lpl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [MEAS_W-1:0] i_measured,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_tag                   o_tag
);

    localparam int NS = DIV_STAGES + 2;

    logic [NS-1:0] r_valid;
    logic [NS-1:0] w_ready;

    always_comb begin
        w_ready[NS-1] = !r_valid[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            w_ready[s] = !r_valid[s] || w_ready[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_ready[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    // clamp to 0..full_scale*100
    logic [TOP_W-1:0]    w_top;
    logic [MEAS_W-2:0]   w_mag;
    logic [TOP_W-1:0]    n_clamp;
    logic [TOP_W-1:0]    r_clamp;
    logic                r_inv0;

    assign w_top = TOP_W'(i_cfg.full_scale) * TOP_W'(100);
    assign w_mag = i_measured[MEAS_W-2:0];

    always_comb begin
        if (i_measured[MEAS_W-1]) begin
            n_clamp = '0;
        end else if (w_mag > (MEAS_W-1)'(w_top)) begin
            n_clamp = w_top;
        end else begin
            n_clamp = w_mag[TOP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_clamp <= n_clamp;
            r_inv0  <= (i_cfg.full_scale == '0);
        end
    end

    // dividend
    logic [NUM_W-1:0] r_num;
    logic             r_inv1;

    always_ff @(posedge i_clk) begin
        if (w_ready[1]) begin
            r_num  <= NUM_W'(r_clamp) * NUM_W'(100);
            r_inv1 <= r_inv0;
        end
    end

    // one quotient bit per stage, msb first
    logic [NUM_W-1:0]  r_rem  [DIV_STAGES];
    logic [FILL_W-1:0] r_quo  [DIV_STAGES];
    logic              r_dinv [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        localparam int QB = DIV_STAGES - 1 - j;

        logic [NUM_W-1:0]  w_rin;
        logic [NUM_W-1:0]  w_sub;
        logic [FILL_W-1:0] w_qin;
        logic [FILL_W-1:0] n_quo;
        logic              w_iin;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rin = r_num;
            assign w_qin = '0;
            assign w_iin = r_inv1;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_qin = r_quo[j-1];
            assign w_iin = r_dinv[j-1];
        end

        assign w_sub = NUM_W'(i_cfg.full_scale) << QB;
        assign w_ge  = (w_rin >= w_sub);

        always_comb begin
            n_quo     = w_qin;
            n_quo[QB] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[j+2]) begin
                r_rem[j]  <= w_ge ? (w_rin - w_sub) : w_rin;
                r_quo[j]  <= n_quo;
                r_dinv[j] <= w_iin;
            end
        end
    end

    assign o_ready   = w_ready[0];
    assign o_valid   = r_valid[NS-1];
    assign o_tag.inv = r_dinv[DIV_STAGES-1];
    assign o_tag.fill = r_dinv[DIV_STAGES-1] ? '0 : r_quo[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/lpl_interp.sv
// piecewise-linear tank table with the segment step truncated toward zero
`default_nettype none

module lpl_interp
    import lpl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_tag             i_tag,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_tag                  o_tag,
    output logic [VOL_W-1:0]      o_vol
);

    localparam int NS        = 5;
    localparam int IDX_W     = 4;
    localparam int OFF_W     = 10;
    localparam int SEG_COUNT = 10;
    localparam int PROD_W    = PT_W + OFF_W;
    localparam int RCP_SH    = 22;
    localparam int RCP_W     = 19;
    localparam int RP_W      = PROD_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP10 = 19'd419431;

    function automatic logic [FILL_W-1:0] seg_base(input logic [IDX_W-1:0] idx);
        return FILL_W'(idx) * FILL_W'(1000);
    endfunction

    function automatic logic [PT_W-1:0] point_at(input t_cfg c,
                                                 input logic [IDX_W-1:0] idx);
        logic [PHI_W+PLO_W-1:0] pts;
        pts = {c.points_high, c.points_low};
        return pts[idx*PT_W +: PT_W];
    endfunction

    logic [NS-1:0] r_valid;
    logic [NS-1:0] w_ready;

    always_comb begin
        w_ready[NS-1] = !r_valid[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            w_ready[s] = !r_valid[s] || w_ready[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_ready[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    // segment index and offset
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] r1_idx;
    logic [OFF_W-1:0] r1_off;
    logic             r1_full;
    t_tag             r1_tag;

    always_comb begin
        n_idx = '0;
        for (int k = 1; k < SEG_COUNT; k++) begin
            if (i_tag.fill >= seg_base(IDX_W'(k))) begin
                n_idx = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r1_idx  <= n_idx;
            r1_off  <= OFF_W'(i_tag.fill - seg_base(n_idx));
            r1_full <= (i_tag.fill >= FILL_MAX);
            r1_tag  <= i_tag;
        end
    end

    // end points
    logic [PT_W-1:0]  w_p0;
    logic [PT_W-1:0]  w_p1;
    logic [PT_W-1:0]  r2_y0;
    logic [PT_W-1:0]  r2_mag;
    logic             r2_neg;
    logic [OFF_W-1:0] r2_off;
    t_tag             r2_tag;

    assign w_p0 = r1_full ? point_at(i_cfg, IDX_W'(SEG_COUNT)) : point_at(i_cfg, r1_idx);
    assign w_p1 = r1_full ? w_p0 : point_at(i_cfg, r1_idx + IDX_W'(1));

    always_ff @(posedge i_clk) begin
        if (w_ready[1]) begin
            r2_y0  <= w_p0;
            r2_mag <= (w_p1 >= w_p0) ? (w_p1 - w_p0) : (w_p0 - w_p1);
            r2_neg <= (w_p1 < w_p0);
            r2_off <= r1_off;
            r2_tag <= r1_tag;
        end
    end

    // rise times offset
    logic [PROD_W-1:0] r3_prod;
    logic [PT_W-1:0]   r3_y0;
    logic              r3_neg;
    t_tag              r3_tag;

    always_ff @(posedge i_clk) begin
        if (w_ready[2]) begin
            r3_prod <= PROD_W'(r2_mag) * PROD_W'(r2_off);
            r3_y0   <= r2_y0;
            r3_neg  <= r2_neg;
            r3_tag  <= r2_tag;
        end
    end

    // step = rise*off*100/1000 = rise*off/10
    logic [RP_W-1:0]  w_rp;
    logic [VOL_W-1:0] r4_step;
    logic [VOL_W-1:0] r4_base;
    logic             r4_neg;
    t_tag             r4_tag;

    assign w_rp = RP_W'(r3_prod) * RP_W'(RECIP10);

    always_ff @(posedge i_clk) begin
        if (w_ready[3]) begin
            r4_step <= w_rp[RCP_SH +: VOL_W];
            r4_base <= VOL_W'(r3_y0) * VOL_W'(100);
            r4_neg  <= r3_neg;
            r4_tag  <= r3_tag;
        end
    end

    logic [VOL_W-1:0] r5_vol;
    t_tag             r5_tag;

    always_ff @(posedge i_clk) begin
        if (w_ready[4]) begin
            r5_vol <= r4_neg ? (r4_base - r4_step) : (r4_base + r4_step);
            r5_tag <= r4_tag;
        end
    end

    assign o_ready = w_ready[0];
    assign o_valid = r_valid[NS-1];
    assign o_tag   = r5_tag;
    assign o_vol   = r5_vol;

endmodule

`default_nettype wire

// File: rtl/core/lpl_dac.sv
// millivolt figure and calibrated dac code, last stage is the output register
`default_nettype none

module lpl_dac
    import lpl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_tag             i_tag,
    input  wire logic [VOL_W-1:0] i_vol,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_tag                  o_tag,
    output logic [VOL_W-1:0]      o_vol,
    output logic [DAC_W-1:0]      o_code
);

    localparam int NS      = 4;
    localparam int V4_W    = VOL_W + 2;
    localparam int T_W     = 2 * V4_W;
    localparam int T_SH    = 20;
    localparam int VOLT_W  = 14;
    localparam int X_W     = 30;
    localparam int M_W     = 31;
    localparam int P_W     = X_W + M_W;
    localparam int Q_SH    = 44;
    localparam logic [V4_W-1:0] RECIP10  = 17'd104858;
    localparam logic [M_W-1:0]  RECIP10K = 31'd1759218605;

    logic [NS-1:0] r_valid;
    logic [NS-1:0] w_ready;

    always_comb begin
        w_ready[NS-1] = !r_valid[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            w_ready[s] = !r_valid[s] || w_ready[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_ready[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    // 4*volume / 10
    logic [T_W-1:0]   r1_t;
    logic [VOL_W-1:0] r1_vol;
    t_tag             r1_tag;

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r1_t   <= T_W'({i_vol, 2'b00}) * T_W'(RECIP10);
            r1_vol <= i_vol;
            r1_tag <= i_tag;
        end
    end

    logic [VOLT_W-1:0] r2_volt;
    logic [VOL_W-1:0]  r2_vol;
    t_tag              r2_tag;

    always_ff @(posedge i_clk) begin
        if (w_ready[1]) begin
            r2_volt <= r1_t[T_SH +: VOLT_W] + VOLT_W'(500);
            r2_vol  <= r1_vol;
            r2_tag  <= r1_tag;
        end
    end

    logic [X_W-1:0]   r3_x;
    logic [VOL_W-1:0] r3_vol;
    t_tag             r3_tag;

    always_ff @(posedge i_clk) begin
        if (w_ready[2]) begin
            r3_x   <= X_W'(r2_volt) * X_W'(i_cfg.dac_gain) + X_W'(i_cfg.dac_offset);
            r3_vol <= r2_vol;
            r3_tag <= r2_tag;
        end
    end

    // divide by 10000, keep the low bits of the quotient
    logic [P_W-1:0]   w_p;
    logic [DAC_W-1:0] r4_code;
    logic [VOL_W-1:0] r4_vol;
    t_tag             r4_tag;

    assign w_p = P_W'(r3_x) * P_W'(RECIP10K);

    always_ff @(posedge i_clk) begin
        if (w_ready[3]) begin
            r4_code <= w_p[Q_SH +: DAC_W];
            r4_vol  <= r3_vol;
            r4_tag  <= r3_tag;
        end
    end

    assign o_ready = w_ready[0];
    assign o_valid = r_valid[NS-1];
    assign o_tag   = r4_tag;
    assign o_vol   = r4_vol;
    assign o_code  = r4_code;

endmodule

`default_nettype wire
